// ===== rtl/tedg_pkg.sv =====
package tedg_pkg;

  // default parameter values
  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 8;

  // register and result formats
  localparam int ALPHA_W    = 17;
  localparam int ALPHA_FRAC = 16;
  localparam int BAND_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 8;
  localparam int OUT_W      = 24;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(1) << ALPHA_FRAC;
  localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(1) << GAIN_FRAC;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BAND  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = CFG_IDX_W'(2);

  // settings shared by both lanes, alpha already limited to one
  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [BAND_W-1:0]  dead_band;
    logic [GAIN_W-1:0]  gain;
  } cfg_t;

  // per word control to the lanes
  typedef struct packed {
    logic load;
    logic seed;
  } lane_ctrl_t;

endpackage

// ===== rtl/tilt_ema_deadzone_gain_core.sv =====
// channel | dir | handshake               | payload
// --------+-----+-------------------------+-------------------------------------
// in      | in  | in_valid_i / in_ready_o | tilt_x_i, tilt_y_i, restart_i
// out     | out | out_valid_o/out_ready_i | accel_x_o, accel_y_o
// cfg     | in  | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// a word first updates both averages on the accept edge (one alpha multiply
// per lane); once the output register has room, the gain product is loaded
// into it. a new word is taken only after the average stage has handed off,
// so no word is accepted while the last one still waits in that stage.
// out_ready_i low holds the result in the output register, and then also
// holds the average stage, which keeps in_ready_o low.
// reset clears the averages, the seeded flag and the handshake state; the
// registers return to alpha one, dead band zero and gain one.
module tilt_ema_deadzone_gain_core #(
  parameter int SampleWidth = tedg_pkg::SAMPLE_WIDTH,
  parameter int FracBits    = tedg_pkg::FRACTION_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration writes
  input  logic                                  cfg_we_i,
  input  logic        [tedg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [tedg_pkg::CFG_W-1:0]     cfg_data_i,
  // sample words
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [SampleWidth-1:0]         tilt_x_i,
  input  logic signed [SampleWidth-1:0]         tilt_y_i,
  input  logic                                  restart_i,
  // result words
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [tedg_pkg::OUT_W-1:0]     accel_x_o,
  output logic signed [tedg_pkg::OUT_W-1:0]     accel_y_o
);
  import tedg_pkg::*;

  // configuration registers
  logic [ALPHA_W-1:0] alpha_q, alpha_d;
  logic [BAND_W-1:0]  band_q, band_d;
  logic [GAIN_W-1:0]  gain_q, gain_d;

  // control
  logic       busy_q, busy_d;     // averages updated, result not yet in output reg
  logic       seeded_q, seeded_d;
  logic       in_fire;
  logic       advance;
  logic       out_space;

  cfg_t       cfg;
  lane_ctrl_t ctrl;

  logic signed [OUT_W-1:0] lane_x, lane_y;

  always_comb begin
    alpha_d = alpha_q;
    band_d  = band_q;
    gain_d  = gain_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALPHA: alpha_d = cfg_data_i[ALPHA_W-1:0];
        CFG_BAND:  band_d  = cfg_data_i[BAND_W-1:0];
        CFG_GAIN:  gain_d  = cfg_data_i[GAIN_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_ONE;
      band_q  <= '0;
      gain_q  <= GAIN_RESET;
    end else begin
      alpha_q <= alpha_d;
      band_q  <= band_d;
      gain_q  <= gain_d;
    end
  end

  // any alpha with the top bit set is at or above one, so clamp to one
  assign cfg.alpha     = alpha_q[ALPHA_W-1] ? ALPHA_ONE : alpha_q;
  assign cfg.dead_band = band_q;
  assign cfg.gain      = gain_q;

  // handshake and sequencing
  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && !busy_q;
  assign advance    = busy_q && out_space;

  always_comb begin
    busy_d   = busy_q;
    seeded_d = seeded_q;
    if (in_fire) begin
      busy_d   = 1'b1;
      seeded_d = 1'b1;
    end else if (advance) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      seeded_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      seeded_q <= seeded_d;
    end
  end

  // first word after reset or a restart seeds both averages
  assign ctrl.load = in_fire;
  assign ctrl.seed = restart_i || !seeded_q;

  // one lane per axis
  tedg_lane #(
    .SampleWidth (SampleWidth),
    .FracBits    (FracBits)
  ) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg),
    .sample_i (tilt_x_i),
    .result_o (lane_x)
  );

  tedg_lane #(
    .SampleWidth (SampleWidth),
    .FracBits    (FracBits)
  ) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg),
    .sample_i (tilt_y_i),
    .result_o (lane_y)
  );

  // output register joins the two lanes into one result word
  tedg_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance),
    .lane_x_i  (lane_x),
    .lane_y_i  (lane_y),
    .space_o   (out_space),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .accel_x_o (accel_x_o),
    .accel_y_o (accel_y_o)
  );

endmodule

// ===== rtl/tedg_lane.sv =====
module tedg_lane #(
  parameter int SampleWidth = tedg_pkg::SAMPLE_WIDTH,
  parameter int FracBits    = tedg_pkg::FRACTION_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tedg_pkg::lane_ctrl_t           ctrl_i,
  input  tedg_pkg::cfg_t                 cfg_i,
  input  logic signed [SampleWidth-1:0]  sample_i,
  output logic signed [tedg_pkg::OUT_W-1:0] result_o
);
  import tedg_pkg::*;

  localparam int AW        = SampleWidth + FracBits;
  localparam int PW        = AW + 1 + ALPHA_W;
  localparam int GW        = AW + GAIN_W + 1;
  localparam int GainShift = FracBits + GAIN_FRAC;

  localparam logic signed [PW-1:0] AlphaHalf = PW'(1) <<< (ALPHA_FRAC - 1);
  localparam logic signed [GW-1:0] GainHalf  = GW'(1) <<< (GainShift - 1);
  localparam logic signed [GW-1:0] OutMax    = GW'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic signed [GW-1:0] OutMin    = ~OutMax;

  logic signed [AW-1:0] avg_q, avg_d;
  logic signed [AW-1:0] target;
  logic signed [AW:0]   diff;
  logic signed [PW-1:0] prod, rnd;
  logic signed [AW-1:0] ema;

  logic        [AW:0]   mag;
  logic        [GW-1:0] band;
  logic signed [AW-1:0] kept;
  logic signed [GW-1:0] gprod, grnd;

  // average update: one multiply by alpha and the rounded step
  assign target = AW'(sample_i) <<< FracBits;
  assign diff   = (AW+1)'(target) - (AW+1)'(avg_q);
  assign prod   = PW'(diff) * PW'($signed({1'b0, cfg_i.alpha}));
  assign rnd    = (prod + AlphaHalf) >>> ALPHA_FRAC;
  assign ema    = AW'((AW+1)'(avg_q) + rnd[AW:0]);

  always_comb begin
    avg_d = avg_q;
    if (ctrl_i.load) begin
      avg_d = ctrl_i.seed ? target : ema;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else begin
      avg_q <= avg_d;
    end
  end

  // dead band, gain and saturation from the stored average
  assign mag   = avg_q[AW-1] ? (AW+1)'(-((AW+1)'(avg_q))) : (AW+1)'(avg_q);
  assign band  = GW'(cfg_i.dead_band) << FracBits;
  assign kept  = (GW'(mag) < band) ? '0 : avg_q;
  assign gprod = GW'(kept) * GW'($signed({1'b0, cfg_i.gain}));
  assign grnd  = (gprod + GainHalf) >>> GainShift;

  always_comb begin
    if (grnd > OutMax) begin
      result_o = OutMax[OUT_W-1:0];
    end else if (grnd < OutMin) begin
      result_o = OutMin[OUT_W-1:0];
    end else begin
      result_o = grnd[OUT_W-1:0];
    end
  end

endmodule

// ===== rtl/tedg_merge.sv =====
module tedg_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic signed [tedg_pkg::OUT_W-1:0] lane_x_i,
  input  logic signed [tedg_pkg::OUT_W-1:0] lane_y_i,
  output logic                              space_o,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [tedg_pkg::OUT_W-1:0] accel_x_o,
  output logic signed [tedg_pkg::OUT_W-1:0] accel_y_o
);
  import tedg_pkg::*;

  logic                    valid_q, valid_d;
  logic signed [OUT_W-1:0] x_q, y_q;

  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // both lanes land in one output word
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= lane_x_i;
      y_q <= lane_y_i;
    end
  end

  assign valid_o   = valid_q;
  assign accel_x_o = x_q;
  assign accel_y_o = y_q;

endmodule

// ===== rtl/tedg_checker.sv =====
module tedg_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [tedg_pkg::OUT_W-1:0] accel_x_o,
  input logic signed [tedg_pkg::OUT_W-1:0] accel_y_o
);

  // one word in flight: an accept closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // a new result only follows a word held in the average stage
  a_result_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a pending word");

  // the average stage drains as soon as the output register has room
  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && (!out_valid_o || out_ready_i) |=> in_ready_o)
    else $error("average stage stuck with room at the output");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(accel_x_o) && $stable(accel_y_o))
    else $error("stalled result changed");

endmodule

bind tilt_ema_deadzone_gain_core tedg_checker u_tedg_checker (.*);
